// ----- hdl/assert_macros.svh -----
// Assertion macros for modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, switched off while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hdl/utf8ds_pkg.sv -----
// Types and constants for the UTF-8 decoder and sanitiser.
package utf8ds_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned LenW = 3;
  localparam int unsigned CntW = 3;

  localparam logic [CpW-1:0] ReplCp    = 21'h00FFFD;
  localparam logic [CpW-1:0] Min2      = 21'h000080;
  localparam logic [CpW-1:0] Min3      = 21'h000800;
  localparam logic [CpW-1:0] Min4      = 21'h010000;
  localparam logic [CpW-1:0] SurrLo    = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi    = 21'h00DFFF;
  localparam logic [CpW-1:0] CpMax     = 21'h10FFFF;

  localparam logic [7:0] Lead2Lo = 8'hC2;
  localparam logic [7:0] Lead2Hi = 8'hDF;
  localparam logic [7:0] Lead3Lo = 8'hE0;
  localparam logic [7:0] Lead3Hi = 8'hEF;
  localparam logic [7:0] Lead4Lo = 8'hF0;
  localparam logic [7:0] Lead4Hi = 8'hF4;

  localparam logic [LenW-1:0] Len1 = 3'd1;
  localparam logic [LenW-1:0] Len2 = 3'd2;
  localparam logic [LenW-1:0] Len3 = 3'd3;
  localparam logic [LenW-1:0] Len4 = 3'd4;

  typedef struct packed {
    logic [1:0]      held;
    logic [LenW-1:0] exp_len;
    logic [CpW-1:0]  part;
  } seq_state_t;

  // Results caused by one byte: replacements first, then at most one decoded unit.
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic            tail;
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    logic            last;
  } burst_t;

endpackage

// ----- hdl/utf8ds_decode.sv -----
// Combinational decode of one byte against the pending sequence state.
module utf8ds_decode (
  input  logic [7:0]              in_byte,
  input  logic                    in_last,
  input  utf8ds_pkg::seq_state_t  st_i,
  output utf8ds_pkg::seq_state_t  st_o,
  output utf8ds_pkg::burst_t      burst_o
);

  logic                             is_cont;
  logic [utf8ds_pkg::LenW-1:0]      have;
  logic [utf8ds_pkg::CpW-1:0]       pv;
  logic [utf8ds_pkg::CpW-1:0]       min_cp;
  logic                             bad_val;
  logic                             lead_ascii;
  logic                             lead2;
  logic                             lead3;
  logic                             lead4;
  logic [utf8ds_pkg::CntW-1:0]      rep;
  logic                             tail;
  logic [utf8ds_pkg::CpW-1:0]       tcp;
  logic [utf8ds_pkg::LenW-1:0]      tlen;

  assign is_cont    = (in_byte[7:6] == 2'b10);
  assign have       = {1'b0, st_i.held} + 3'd1;
  assign pv         = {st_i.part[14:0], in_byte[5:0]};
  assign lead_ascii = ~in_byte[7];
  assign lead2      = (in_byte >= utf8ds_pkg::Lead2Lo) && (in_byte <= utf8ds_pkg::Lead2Hi);
  assign lead3      = (in_byte >= utf8ds_pkg::Lead3Lo) && (in_byte <= utf8ds_pkg::Lead3Hi);
  assign lead4      = (in_byte >= utf8ds_pkg::Lead4Lo) && (in_byte <= utf8ds_pkg::Lead4Hi);

  always_comb begin
    unique case (st_i.exp_len)
      utf8ds_pkg::Len2: min_cp = utf8ds_pkg::Min2;
      utf8ds_pkg::Len3: min_cp = utf8ds_pkg::Min3;
      default:          min_cp = utf8ds_pkg::Min4;
    endcase
  end

  assign bad_val = (pv < min_cp) || (pv > utf8ds_pkg::CpMax) ||
                   ((pv >= utf8ds_pkg::SurrLo) && (pv <= utf8ds_pkg::SurrHi));

  always_comb begin
    st_o = st_i;
    rep  = '0;
    tail = 1'b0;
    tcp  = '0;
    tlen = utf8ds_pkg::Len1;
    if ((st_i.held != 2'd0) && is_cont) begin
      if (have >= st_i.exp_len) begin
        st_o = '0;
        if (bad_val) begin
          rep = st_i.exp_len;
        end else begin
          tail = 1'b1;
          tcp  = pv;
          tlen = st_i.exp_len;
        end
      end else begin
        st_o.held = have[1:0];
        st_o.part = pv;
        if (in_last) begin
          rep  = have;
          st_o = '0;
        end
      end
    end else begin
      // Any held bytes are flushed, then the byte starts afresh as a lead.
      rep  = {1'b0, st_i.held};
      st_o = '0;
      if (lead_ascii) begin
        tail = 1'b1;
        tcp  = {13'd0, in_byte};
      end else if (lead2 || lead3 || lead4) begin
        if (in_last) begin
          rep = rep + 3'd1;
        end else begin
          st_o.held = 2'd1;
          if (lead2) begin
            st_o.exp_len = utf8ds_pkg::Len2;
            st_o.part    = {16'd0, in_byte[4:0]};
          end else if (lead3) begin
            st_o.exp_len = utf8ds_pkg::Len3;
            st_o.part    = {17'd0, in_byte[3:0]};
          end else begin
            st_o.exp_len = utf8ds_pkg::Len4;
            st_o.part    = {18'd0, in_byte[2:0]};
          end
        end
      end else begin
        rep = rep + 3'd1;
      end
    end
  end

  assign burst_o.cnt  = rep + {2'b00, tail};
  assign burst_o.tail = tail;
  assign burst_o.cp   = tcp;
  assign burst_o.len  = tlen;
  assign burst_o.last = in_last;

endmodule

// ----- hdl/utf8_stream_decoder_sanitizer_unit.sv -----
// Top level of the strict UTF-8 decoder that replaces bad bytes with U+FFFD.
// The first result of a byte is offered in the cycle after its beat is accepted.
// One byte per cycle while out_tready is high; a byte that yields several results holds
// the input while the result register drains, one result per cycle unless out_tready stalls it.
// Reset clears the pending sequence and drops any results not yet delivered.
`include "assert_macros.svh"

module utf8_stream_decoder_sanitizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] src_length
  output logic [0:0]  out_tuser,  // [0] is_valid
  output logic        out_tlast
);

  utf8ds_pkg::seq_state_t        st_r;
  utf8ds_pkg::seq_state_t        st_nxt;
  utf8ds_pkg::burst_t            burst_nxt;
  utf8ds_pkg::burst_t            burst_r;
  logic [utf8ds_pkg::CntW-1:0]   cnt_r;
  logic                          in_acc;
  logic                          out_acc;
  logic                          final_beat;
  logic                          show_tail;
  logic                          slot_free;
  logic                          pend_ok;
  logic                          tail_cp_ok;

  utf8ds_decode u_decode (
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .st_i    (st_r),
    .st_o    (st_nxt),
    .burst_o (burst_nxt)
  );

  assign in_tready = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      cnt_r <= '0;
    end else if (in_acc) begin
      st_r  <= st_nxt;
      cnt_r <= burst_nxt.cnt;
    end else if (out_acc) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      burst_r <= burst_nxt;
    end
  end

  assign final_beat = (cnt_r == 3'd1);
  assign show_tail  = final_beat && burst_r.tail;

  assign out_tvalid     = (cnt_r != 3'd0);
  assign out_tdata      = {show_tail ? burst_r.len : utf8ds_pkg::Len1,
                           show_tail ? burst_r.cp  : utf8ds_pkg::ReplCp};
  assign out_tuser[0]   = show_tail;
  assign out_tlast      = final_beat && burst_r.last;

  assign slot_free  = (cnt_r == 3'd0) || (final_beat && out_tready);
  assign pend_ok    = ({1'b0, st_r.held} < st_r.exp_len);
  assign tail_cp_ok = (out_tdata[20:0] <= utf8ds_pkg::CpMax) &&
                      ((out_tdata[20:0] < utf8ds_pkg::SurrLo) ||
                       (out_tdata[20:0] > utf8ds_pkg::SurrHi));

  `ASSERT_CLK(a_cnt_range, clk, rst_n, cnt_r <= 3'd4, "result count above four")
  `ASSERT_IMPL(a_no_overrun, clk, rst_n, in_acc, slot_free, "byte accepted while results remain")
  `ASSERT_IMPL(a_pending_len, clk, rst_n, st_r.held != 2'd0, pend_ok, "pending sequence complete")
  `ASSERT_IMPL(a_valid_scalar, clk, rst_n, show_tail, tail_cp_ok, "decoded value not a scalar")

endmodule
